/* hw/rtl/kprl_pkg.sv */
// shared constants and types of the per-key press rate limiter
package kprl_pkg;

    localparam int ADDR_W        = 16;
    localparam int TIME_W        = 32;
    localparam int DEF_ENTRIES   = 16;
    localparam logic [TIME_W-1:0] DELAY_RESET = 32'd200;

    // mode codes of an input word
    localparam logic MODE_PRESS = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

    // outcome of a tag lookup
    typedef struct packed {
        logic tracked;   // a slot matched or was claimed
        logic is_new;    // the slot was claimed by this press
    } t_lookup;

endpackage

/* hw/rtl/kprl_tag_table.sv */
// valid bits and button addresses, parallel match and free slot claim
module kprl_tag_table
    import kprl_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEF_ENTRIES,
    parameter int SLOT_W        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_press,
    input  logic              i_clear,
    input  logic [ADDR_W-1:0] i_addr,
    output logic [SLOT_W-1:0] o_slot,
    output t_lookup           o_lookup
);

    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [ADDR_W-1:0]        r_addr [TABLE_ENTRIES];

    logic [SLOT_W-1:0] hit_slot;
    logic [SLOT_W-1:0] free_slot;
    logic              hit;
    logic              free;

    // lowest matching valid slot and lowest free slot
    always_comb begin
        hit       = 1'b0;
        free      = 1'b0;
        hit_slot  = '0;
        free_slot = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (r_valid[i] && (r_addr[i] == i_addr)) begin
                hit      = 1'b1;
                hit_slot = SLOT_W'(i);
            end
            if (!r_valid[i]) begin
                free      = 1'b1;
                free_slot = SLOT_W'(i);
            end
        end
    end

    assign o_slot           = hit ? hit_slot : free_slot;
    assign o_lookup.tracked = hit || free;
    assign o_lookup.is_new  = !hit && free;

    // valid bits: clear wipes all, a claim sets one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_clear) begin
            r_valid <= '0;
        end else if (i_press && o_lookup.is_new) begin
            r_valid[free_slot] <= 1'b1;
        end
    end

    // address of a claimed slot
    always_ff @(posedge i_clk) begin
        if (i_press && !i_clear && o_lookup.is_new) begin
            r_addr[free_slot] <= i_addr;
        end
    end

endmodule

/* hw/rtl/kprl_time_ram.sv */
// last accepted press time per slot, one write and one registered read port
module kprl_time_ram
    import kprl_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEF_ENTRIES,
    parameter int SLOT_W        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [SLOT_W-1:0] i_waddr,
    input  logic [TIME_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [SLOT_W-1:0] i_raddr,
    output logic [TIME_W-1:0] o_rdata
);

    logic [TIME_W-1:0] r_mem [TABLE_ENTRIES];
    logic [TIME_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/per_key_press_rate_limiter_top.sv */
// Per-button press rate limiter. Each input word is a press (button address plus a
// wrapping millisecond timestamp) or a clear command, and yields one result word.
// Button addresses sit in a flip-flop tag table that is matched in parallel, and the
// time of the last accepted press of each slot sits in a single-port-read memory.
// A word is looked up and its slot read in the cycle it is accepted; the check stage
// then compares the elapsed time against the delay register, writes the slot back and
// loads the output register, and holds while the output register is stalled. One word
// per cycle is taken while the output is drained; a write-back to the slot that the
// next word reads is forwarded. Table size is TABLE_ENTRIES.
module per_key_press_rate_limiter_top
    import kprl_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEF_ENTRIES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [TIME_W-1:0] i_cfg_data,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_mode,
    input  logic [ADDR_W-1:0] i_button_address,
    input  logic [TIME_W-1:0] i_current_time_ms,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_accepted,
    output logic              o_tracked
);

    localparam int SLOT_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    logic [TIME_W-1:0] r_delay;

    logic              in_accept;
    logic              press;
    logic              clear;
    logic [SLOT_W-1:0] lk_slot;
    t_lookup           lk;

    logic              r_s2_valid;
    logic              r_s2_mode;
    t_lookup           r_s2_lk;
    logic [SLOT_W-1:0] r_s2_slot;
    logic [TIME_W-1:0] r_s2_time;
    logic              r_fwd_hit;
    logic [TIME_W-1:0] r_fwd_time;

    logic              r_out_valid;
    logic              r_accepted;
    logic              r_tracked;

    logic              s2_advance;
    logic [TIME_W-1:0] ram_rdata;
    logic [TIME_W-1:0] prev_time;
    logic [TIME_W-1:0] elapsed;
    logic              pass;
    logic              s2_press;
    logic              s2_we;
    logic [TIME_W-1:0] s2_wdata;

    // handshakes
    assign s2_advance = !r_out_valid || i_ready;
    assign o_ready    = !r_s2_valid || s2_advance;
    assign in_accept  = i_valid && o_ready;
    assign press      = in_accept && (i_mode == MODE_PRESS);
    assign clear      = in_accept && (i_mode == MODE_CLEAR);

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay <= DELAY_RESET;
        end else if (i_cfg_we) begin
            r_delay <= i_cfg_data;
        end
    end

    kprl_tag_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .SLOT_W        (SLOT_W)
    ) u_tags (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_press  (press),
        .i_clear  (clear),
        .i_addr   (i_button_address),
        .o_slot   (lk_slot),
        .o_lookup (lk)
    );

    kprl_time_ram #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .SLOT_W        (SLOT_W)
    ) u_times (
        .i_clk   (i_clk),
        .i_we    (s2_we),
        .i_waddr (r_s2_slot),
        .i_wdata (s2_wdata),
        .i_re    (press),
        .i_raddr (lk_slot),
        .o_rdata (ram_rdata)
    );

    // check stage: a fresh slot starts at time zero
    assign prev_time = r_s2_lk.is_new ? '0 : (r_fwd_hit ? r_fwd_time : ram_rdata);
    assign elapsed   = r_s2_time - prev_time;
    assign pass      = elapsed >= r_delay;
    assign s2_press  = (r_s2_mode == MODE_PRESS) && r_s2_lk.tracked;
    assign s2_we     = r_s2_valid && s2_advance && s2_press && (pass || r_s2_lk.is_new);
    assign s2_wdata  = pass ? r_s2_time : '0;

    // check stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (in_accept) begin
            r_s2_valid <= 1'b1;
        end else if (s2_advance) begin
            r_s2_valid <= 1'b0;
        end
    end

    // check stage word and write-back forwarding
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s2_mode  <= i_mode;
            r_s2_lk    <= lk;
            r_s2_slot  <= lk_slot;
            r_s2_time  <= i_current_time_ms;
            r_fwd_hit  <= s2_we && (r_s2_slot == lk_slot);
            r_fwd_time <= s2_wdata;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_accepted  <= 1'b0;
            r_tracked   <= 1'b0;
        end else if (s2_advance) begin
            r_out_valid <= r_s2_valid;
            if (r_s2_valid) begin
                r_accepted <= (r_s2_mode == MODE_PRESS) && (!r_s2_lk.tracked || pass);
                r_tracked  <= s2_press;
            end
        end
    end

    assign o_valid    = r_out_valid;
    assign o_accepted = r_accepted;
    assign o_tracked  = r_tracked;

endmodule

/* verif/per_key_press_rate_limiter_top_tb.sv */
// self-checking bench for the per-key press rate limiter: directed table, then random words
module per_key_press_rate_limiter_top_tb;
    import kprl_pkg::*;

    // verdict carried by one result word
    typedef struct packed {
        logic accepted;
        logic tracked;
    } verdict_t;

    // one row of the directed table
    typedef struct packed {
        logic              mode;
        logic [ADDR_W-1:0] addr;
        logic [TIME_W-1:0] ms;
        bit                typed;
        verdict_t          want;
    } press_row_t;

    logic              i_clk             = 1'b0;
    logic              i_rst_n           = 1'b0;
    logic              i_cfg_we          = 1'b0;
    logic [TIME_W-1:0] i_cfg_data        = '0;
    logic              i_valid           = 1'b0;
    logic              o_ready;
    logic              i_mode            = MODE_PRESS;
    logic [ADDR_W-1:0] i_button_address  = '0;
    logic [TIME_W-1:0] i_current_time_ms = '0;
    logic              o_valid;
    logic              i_ready           = 1'b0;
    logic              o_accepted;
    logic              o_tracked;

    // mirror of the slot table and the delay register
    logic              slot_valid [DEF_ENTRIES];
    logic [ADDR_W-1:0] slot_addr  [DEF_ENTRIES];
    logic [TIME_W-1:0] slot_last  [DEF_ENTRIES];
    logic [TIME_W-1:0] delay_ms = DELAY_RESET;

    verdict_t pending_verdicts[$];
    int       mismatch_count = 0;
    int       results_seen   = 0;
    bit       gaps_on        = 1'b1;
    bit       hold_request   = 1'b0;
    int       ready_stall    = 0;

    per_key_press_rate_limiter_top #(
        .TABLE_ENTRIES(DEF_ENTRIES)
    ) i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_mode           (i_mode),
        .i_button_address (i_button_address),
        .i_current_time_ms(i_current_time_ms),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_accepted       (o_accepted),
        .o_tracked        (o_tracked)
    );

    // clock
    initial begin : clock_gen
        forever #4 i_clk = ~i_clk;
    end

    // fixed time limit on the whole run
    initial begin : watchdog
        #3_000_000;
        $display("Mismatches found");
        $finish;
    end

    task automatic report_mismatch(string msg);
        mismatch_count++;
        $display("%0t: word %0d: %s", $time, results_seen, msg);
    endtask

    function automatic void wipe_slots();
        for (int i = 0; i < DEF_ENTRIES; i++) begin
            slot_valid[i] = 1'b0;
            slot_addr[i]  = '0;
            slot_last[i]  = '0;
        end
    endfunction

    // verdict of one input word, updating the mirrored table
    function automatic verdict_t judge_press_word(logic mode, logic [ADDR_W-1:0] addr,
                                                  logic [TIME_W-1:0] ms);
        verdict_t          v;
        int                slot;
        logic [TIME_W-1:0] elapsed;
        v    = '0;
        slot = -1;
        if (mode == MODE_CLEAR) begin
            wipe_slots();
            return v;
        end
        for (int i = 0; i < DEF_ENTRIES; i++)
            if (slot < 0 && slot_valid[i] && slot_addr[i] == addr)
                slot = i;
        // no match: claim the lowest free slot with its time at zero
        for (int i = 0; i < DEF_ENTRIES; i++) begin
            if (slot < 0 && !slot_valid[i]) begin
                slot          = i;
                slot_valid[i] = 1'b1;
                slot_addr[i]  = addr;
                slot_last[i]  = '0;
            end
        end
        // table full: let it through untracked
        if (slot < 0) begin
            v.accepted = 1'b1;
            return v;
        end
        v.tracked = 1'b1;
        elapsed   = ms - slot_last[slot];
        if (elapsed >= delay_ms) begin
            slot_last[slot] = ms;
            v.accepted      = 1'b1;
        end
        return v;
    endfunction

    function automatic press_row_t mk_row(logic mode, logic [ADDR_W-1:0] addr,
                                          logic [TIME_W-1:0] ms, bit typed,
                                          logic acc, logic trk);
        press_row_t r;
        r.mode           = mode;
        r.addr           = addr;
        r.ms             = ms;
        r.typed          = typed;
        r.want.accepted  = acc;
        r.want.tracked   = trk;
        return r;
    endfunction

    // present one word, after a random gap when gaps are on, and hold it until taken
    task automatic offer_word(logic mode, logic [ADDR_W-1:0] addr, logic [TIME_W-1:0] ms,
                              bit typed, verdict_t want);
        int       gap;
        verdict_t got;
        gap = gaps_on ? $urandom_range(0, 13) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid           <= 1'b1;
        i_mode            <= mode;
        i_button_address  <= addr;
        i_current_time_ms <= ms;
        do @(posedge i_clk); while (!o_ready);
        got = judge_press_word(mode, addr, ms);
        pending_verdicts.push_back(typed ? want : got);
    endtask

    // stop offering and wait until every result is back
    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_delay(logic [TIME_W-1:0] value);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        delay_ms = value;
    endtask

    // random words around a pool of buttons a little larger than the table
    task automatic run_random_phase(int n_words);
        logic [ADDR_W-1:0] pool[20];
        logic [ADDR_W-1:0] addr;
        logic [TIME_W-1:0] base;
        logic [TIME_W-1:0] ms;
        logic              mode;
        int                pick;
        verdict_t          none;
        none = '0;
        foreach (pool[i]) pool[i] = ADDR_W'($urandom);
        for (int n = 0; n < n_words; n++) begin
            mode = ($urandom_range(0, 59) == 0) ? MODE_CLEAR : MODE_PRESS;
            addr = ($urandom_range(0, 9) == 0) ? ADDR_W'($urandom) : pool[$urandom_range(0, 19)];
            base = '0;
            for (int i = 0; i < DEF_ENTRIES; i++)
                if (slot_valid[i] && slot_addr[i] == addr)
                    base = slot_last[i];
            // mostly aim at the delay boundary, some anywhere, the rest shortly after the last time
            pick = $urandom_range(0, 9);
            if (pick < 6)
                ms = base + delay_ms + TIME_W'($urandom_range(0, 4)) - TIME_W'(2);
            else if (pick < 8)
                ms = $urandom;
            else
                ms = base + TIME_W'($urandom_range(0, 255));
            offer_word(mode, addr, ms, 1'b0, none);
        end
    endtask

    // output side: random stalls, and one long hold-off on request
    initial begin : result_side
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                ready_stall  = 70;
            end
            if (ready_stall > 0) begin
                i_ready <= 1'b0;
                ready_stall--;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // compare each taken result with the oldest pending verdict
    always @(posedge i_clk) begin : result_check
        verdict_t want;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (pending_verdicts.size() == 0) begin
                report_mismatch($sformatf("unexpected result accepted=%0b tracked=%0b",
                                          o_accepted, o_tracked));
            end else begin
                want = pending_verdicts.pop_front();
                if (o_accepted !== want.accepted)
                    report_mismatch($sformatf("accepted %0b, wanted %0b",
                                              o_accepted, want.accepted));
                if (o_tracked !== want.tracked)
                    report_mismatch($sformatf("tracked %0b, wanted %0b",
                                              o_tracked, want.tracked));
            end
            ready_stall = gaps_on ? $urandom_range(0, 13) : 0;
        end
    end

    initial begin : stimulus
        press_row_t steps[$];
        wipe_slots();
        // directed rows at the reset delay of 200 ms
        steps.push_back(mk_row(MODE_PRESS, 16'h0000, 32'd0,        1'b1, 1'b0, 1'b1));
        steps.push_back(mk_row(MODE_PRESS, 16'h0000, 32'd199,      1'b1, 1'b0, 1'b1));
        steps.push_back(mk_row(MODE_PRESS, 16'h0000, 32'd200,      1'b1, 1'b1, 1'b1));
        steps.push_back(mk_row(MODE_PRESS, 16'hFFFF, 32'hFFFFFFFF, 1'b1, 1'b1, 1'b1));
        // elapsed time wrapping past zero
        steps.push_back(mk_row(MODE_PRESS, 16'hFFFF, 32'h00000050, 1'b0, 1'b0, 1'b0));
        steps.push_back(mk_row(MODE_PRESS, 16'hFFFF, 32'h000000C7, 1'b0, 1'b0, 1'b0));
        steps.push_back(mk_row(MODE_CLEAR, 16'h5A5A, 32'h12345678, 1'b1, 1'b0, 1'b0));
        // fresh slot after a clear, rejected yet kept
        steps.push_back(mk_row(MODE_PRESS, 16'h0000, 32'd100,      1'b1, 1'b0, 1'b1));
        for (int a = 1; a < DEF_ENTRIES; a++)
            steps.push_back(mk_row(MODE_PRESS, ADDR_W'(a), 32'd1000, 1'b0, 1'b0, 1'b0));
        // table full
        steps.push_back(mk_row(MODE_PRESS, 16'h1234, 32'd1000,     1'b1, 1'b1, 1'b0));
        steps.push_back(mk_row(MODE_CLEAR, 16'hFFFF, 32'hFFFFFFFF, 1'b1, 1'b0, 1'b0));

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (steps[k])
            offer_word(steps[k].mode, steps[k].addr, steps[k].ms, steps[k].typed, steps[k].want);
        drain_results();

        // random phases over a spread of delays
        run_random_phase(254);
        set_delay(32'd0);
        gaps_on      = 1'b0;
        hold_request = 1'b1;
        run_random_phase(254);
        set_delay(32'hFFFFFFFF);
        gaps_on = 1'b1;
        run_random_phase(254);
        set_delay(32'd1);
        run_random_phase(254);
        set_delay($urandom);
        run_random_phase(254);
        set_delay($urandom_range(50, 5000));
        gaps_on = 1'b0;
        run_random_phase(254);

        drain_results();
        repeat (6) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/kprl_pkg.sv
hw/rtl/kprl_tag_table.sv
hw/rtl/kprl_time_ram.sv
hw/rtl/per_key_press_rate_limiter_top.sv
verif/per_key_press_rate_limiter_top_tb.sv
